>>> rtl/saq_pkg.sv
// ----------------------------------------------------------------------------
// saq_pkg
// Shared types and constants for the sorted alarm queue.
// ----------------------------------------------------------------------------
package saq_pkg;

	localparam int unsigned IdW = 2;
	localparam int unsigned TimeW = 32;
	localparam logic [TimeW-1:0] NoDeadline = 32'hFFFF_FFFF;

	localparam logic OpcArm = 1'b0;
	localparam logic OpcTick = 1'b1;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_REMOVE = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_POP    = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic             vld;
		logic [IdW-1:0]   id;
		logic [TimeW-1:0] dl;
	} entry_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IdW-1:0]   id;
		logic [TimeW-1:0] dl;
		logic [TimeW-1:0] now;
	} cell_ctrl_t;

endpackage

>>> rtl/sorted_alarm_queue.sv
// ----------------------------------------------------------------------------
// sorted_alarm_queue
// Deadline-sorted alarm queue driving one shared compare value.
// ----------------------------------------------------------------------------
// Words are taken on start while busy is low; results come out one per cycle
// on strobe and cannot be held off. An arm runs a remove pass, an insert pass
// and then gives its result. A tick pops expired alarms off the head, one pop
// through the cell row per cycle, with one word per pop, or one non-fired
// word if none has expired. compare_value always shows the current head
// deadline, or all ones when the queue is empty, and is valid with strobe.
module sorted_alarm_queue #(
	parameter int unsigned NUM_ALARMS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [1:0]  alarm_id,
	input  logic [31:0] delay_us,
	input  logic [31:0] now,
	output logic        strobe,
	output logic        fired_valid,
	output logic [1:0]  fired_id,
	output logic        last,
	output logic [31:0] compare_value
);
	import saq_pkg::*;

	localparam logic [4:0] NumSlots = 5'(NUM_ALARMS);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REMOVE = 4'b0010,
		ST_INSERT = 4'b0100,
		ST_POP    = 4'b1000
	} state_t;

	state_t           state_q;
	logic [IdW-1:0]   id_q;
	logic [TimeW-1:0] dl_q;
	logic [TimeW-1:0] now_q;
	logic             ign_q;

	logic             strobe_q;
	logic             fired_q;
	logic [IdW-1:0]   fid_q;
	logic             last_q;

	cell_ctrl_t ctrl;
	entry_t     ent   [NUM_ALARMS];
	entry_t     right [NUM_ALARMS];
	entry_t     left  [NUM_ALARMS];
	logic       keep_w [NUM_ALARMS];
	logic       rm_w   [NUM_ALARMS];
	logic       exp_w  [NUM_ALARMS];
	logic       lkeep  [NUM_ALARMS];
	logic       lrm    [NUM_ALARMS];
	logic       next_exp;
	logic       accept;
	logic       done;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	for (genvar i = 0; i < NUM_ALARMS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left[i]  = '0;
			assign lkeep[i] = 1'b1;
			assign lrm[i]   = 1'b0;
		end else begin : g_mid
			assign left[i]  = ent[i-1];
			assign lkeep[i] = keep_w[i-1];
			assign lrm[i]   = rm_w[i-1];
		end
		if (i == NUM_ALARMS - 1) begin : g_last
			assign right[i] = '0;
		end else begin : g_inner
			assign right[i] = ent[i+1];
		end
		saq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left      (left[i]),
			.left_keep (lkeep[i]),
			.left_rm   (lrm[i]),
			.right     (right[i]),
			.entry     (ent[i]),
			.keep      (keep_w[i]),
			.rm        (rm_w[i]),
			.expired   (exp_w[i])
		);
	end

	if (NUM_ALARMS > 1) begin : g_next
		assign next_exp = exp_w[1];
	end else begin : g_single
		assign next_exp = 1'b0;
	end

	always_comb begin
		ctrl.op  = CELL_HOLD;
		ctrl.id  = id_q;
		ctrl.dl  = dl_q;
		ctrl.now = now_q;
		done     = 1'b0;
		unique case (state_q)
			ST_IDLE:   ctrl.op = CELL_HOLD;
			ST_REMOVE: ctrl.op = CELL_REMOVE;
			ST_INSERT: begin
				if (!ign_q && !ent[NUM_ALARMS-1].vld) ctrl.op = CELL_INSERT;
				done = 1'b1;
			end
			ST_POP: begin
				if (exp_w[0]) begin
					ctrl.op = CELL_POP;
					done    = !next_exp;
				end else begin
					done = 1'b1;
				end
			end
			default: ctrl.op = CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_INSERT) || (state_q == ST_POP);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= (opcode == OpcTick) ? ST_POP : ST_REMOVE;
				end
				ST_REMOVE: state_q <= ST_INSERT;
				ST_INSERT: state_q <= ST_IDLE;
				ST_POP: begin
					if (done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q  <= alarm_id;
			dl_q  <= now + delay_us;
			now_q <= now;
			ign_q <= ({3'b000, alarm_id} >= NumSlots);
		end
		fired_q <= (state_q == ST_POP) && exp_w[0];
		fid_q   <= ((state_q == ST_POP) && exp_w[0]) ? ent[0].id : '0;
		last_q  <= done;
	end

	assign strobe        = strobe_q;
	assign fired_valid   = fired_q;
	assign fired_id      = fid_q;
	assign last          = last_q;
	assign compare_value = ent[0].vld ? ent[0].dl : NoDeadline;

`ifndef SYNTHESIS
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("pop run broke off before its last word");

	a_idle_word_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !fired_valid |-> last)
		else $error("non-fired word not marked last");

	a_finish_word: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("busy dropped without a final word");

	for (genvar k = 0; k + 1 < NUM_ALARMS; k++) begin : g_chk
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			ent[k+1].vld |-> ent[k].vld && (ent[k].dl <= ent[k+1].dl))
			else $error("cell row out of order");
	end
`endif

endmodule

>>> rtl/saq_cell.sv
// ----------------------------------------------------------------------------
// saq_cell
// One queue position: slot id and deadline, shifts with its neighbors.
// ----------------------------------------------------------------------------
module saq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  saq_pkg::cell_ctrl_t ctrl,
	input  saq_pkg::entry_t    left,
	input  logic               left_keep,
	input  logic               left_rm,
	input  saq_pkg::entry_t    right,
	output saq_pkg::entry_t    entry,
	output logic               keep,
	output logic               rm,
	output logic               expired
);
	import saq_pkg::*;

	logic             vld_q;
	logic [IdW-1:0]   id_q;
	logic [TimeW-1:0] dl_q;
	entry_t           ent_q;
	entry_t           ent_d;

	assign ent_q   = '{vld: vld_q, id: id_q, dl: dl_q};
	assign entry   = ent_q;
	assign keep    = ent_q.vld && (ent_q.dl <= ctrl.dl);
	assign rm      = left_rm || (ent_q.vld && (ent_q.id == ctrl.id));
	assign expired = ent_q.vld && (ent_q.dl < ctrl.now);

	always_comb begin
		ent_d = ent_q;
		unique case (ctrl.op)
			CELL_HOLD: ent_d = ent_q;
			CELL_REMOVE: begin
				if (rm) ent_d = right;
			end
			CELL_INSERT: begin
				if (!keep) begin
					if (left_keep) begin
						ent_d.vld = 1'b1;
						ent_d.id  = ctrl.id;
						ent_d.dl  = ctrl.dl;
					end else begin
						ent_d = left;
					end
				end
			end
			CELL_POP: ent_d = right;
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= ent_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		id_q <= ent_d.id;
		dl_q <= ent_d.dl;
	end

endmodule
